>>> sv/sat_pkg.sv
package sat_pkg;

    localparam int MAX_MESSAGES = 1024;
    localparam int ROW_W        = 32;
    localparam int ROW_CNT      = MAX_MESSAGES / ROW_W;
    localparam int ROW_AW       = $clog2(ROW_CNT);
    localparam int BIT_AW       = $clog2(ROW_W);

    localparam logic OP_ACK  = 1'b0;
    localparam logic OP_SEND = 1'b1;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [1:0] CFG_TOTAL  = 2'd0;
    localparam logic [1:0] CFG_BURST  = 2'd1;
    localparam logic [1:0] CFG_TARGET = 2'd2;

    localparam logic [10:0] TOTAL_RESET  = 11'd0;
    localparam logic [4:0]  BURST_RESET  = 5'd10;
    localparam logic [10:0] TARGET_RESET = 11'd20;
    localparam logic [4:0]  BURST_CAP    = 5'd16;
    localparam logic [10:0] FIELD_MAX11  = 11'd2047;

    typedef struct packed {
        logic        opcode;
        logic [31:0] ack_index;
        logic [15:0] datagram_length;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [9:0]  message_index;
        logic [10:0] acked_count;
        logic [10:0] remaining;
        logic        done_res;
        logic        last;
    } result_t;

endpackage

>>> sv/sat_row_unit.sv
module sat_row_unit (
    input  logic [sat_pkg::ROW_W-1:0]  word,
    output logic [sat_pkg::BIT_AW:0]   ones,
    output logic [sat_pkg::BIT_AW-1:0] first
);
    import sat_pkg::*;

    always_comb
    begin
        ones = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            ones = ones + (BIT_AW+1)'(word[i]);
        end
    end

    always_comb
    begin
        first = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                first = BIT_AW'(i);
            end
        end
    end

endmodule

>>> sv/selective_ack_tracker.sv
// Selective-repeat acknowledgement tracker. After reset the block clears every
// row of its mark store with busy high. An ack request reads the row of its
// index, sets the mark if the ack is valid and new, and gives one status result.
// A send request with nothing pending gives one result of kind none; otherwise
// it reads the 32-message rows of the mark store in order and emits unmarked
// indices, one result each, at most sixteen. The first request after
// message_total is written also recounts the marks, row by row.
// Results appear for exactly one cycle with result_strobe high and cannot be
// held off, so the receiver must take every result as it comes.
module selective_ack_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sat_pkg::cmd_t    cmd,
    output logic             result_strobe,
    output sat_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [10:0]      cfg_data
);
    import sat_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RC_RD,
        ST_RC_ACC,
        ST_DISPATCH,
        ST_ACK_RD,
        ST_ACK_WR,
        ST_ACK_OUT,
        ST_SEND_SETUP,
        ST_SEND_RD,
        ST_SEND_LOAD,
        ST_SEND_PICK
    } state_t;

    state_t             state_reg;
    logic [10:0]        total_reg;
    logic [4:0]         burst_reg;
    logic [10:0]        target_reg;
    logic               op_reg;
    logic [9:0]         idx_reg;
    logic               ack_ok_reg;
    logic [ROW_AW:0]    row_reg;
    logic [10:0]        acc_reg;
    logic [10:0]        set_below_reg;
    logic               stale_reg;
    logic [10:0]        confirmed_reg;
    logic [ROW_W-1:0]   work_reg;
    logic [4:0]         send_goal_reg;
    logic [4:0]         send_cnt_reg;
    logic               strobe_reg;
    result_t            result_reg;

    logic [ROW_W-1:0]   mark_mem [ROW_CNT];
    logic [ROW_W-1:0]   mark_rd_reg;
    logic               mem_we;
    logic [ROW_AW-1:0]  mem_wr_addr;
    logic [ROW_W-1:0]   mem_wr_data;
    logic [ROW_AW-1:0]  mem_rd_addr;

    logic [10:0]        n_eff;
    logic [ROW_AW:0]    n_rows;
    logic [ROW_W-1:0]   cur_mask;
    logic [10:0]        open_cnt;
    logic [10:0]        goal;
    logic               done_now;
    logic [4:0]         limit;
    logic [ROW_W-1:0]   unit_word;
    logic [BIT_AW:0]    unit_ones;
    logic [BIT_AW-1:0]  unit_first;
    logic               ack_hit;
    logic [11:0]        n_round;

    assign n_eff   = (total_reg > 11'(MAX_MESSAGES)) ? 11'(MAX_MESSAGES) : total_reg;
    assign n_round = {1'b0, n_eff} + 12'(ROW_W - 1);
    assign n_rows  = (ROW_AW+1)'(n_round >> BIT_AW);
    assign open_cnt = n_eff - set_below_reg;
    assign goal     = (target_reg < n_eff) ? target_reg : n_eff;
    assign done_now = (confirmed_reg >= goal) || (open_cnt == 11'd0);
    assign busy     = (state_reg != ST_IDLE);
    assign ack_hit  = ack_ok_reg && !mark_rd_reg[idx_reg[BIT_AW-1:0]];

    always_comb
    begin
        if (burst_reg == 5'd0)
        begin
            limit = 5'd1;
        end
        else if (burst_reg > BURST_CAP)
        begin
            limit = BURST_CAP;
        end
        else
        begin
            limit = burst_reg;
        end
    end

    // Valid bits of the current row: those whose message number is below the total.
    always_comb
    begin
        if (row_reg < (ROW_AW+1)'(n_eff >> BIT_AW))
        begin
            cur_mask = '1;
        end
        else if (row_reg == (ROW_AW+1)'(n_eff >> BIT_AW))
        begin
            cur_mask = (ROW_W'(1) << n_eff[BIT_AW-1:0]) - ROW_W'(1);
        end
        else
        begin
            cur_mask = '0;
        end
    end

    assign unit_word = (state_reg == ST_RC_ACC) ? (mark_rd_reg & cur_mask) : work_reg;

    sat_row_unit u_row (
        .word  (unit_word),
        .ones  (unit_ones),
        .first (unit_first)
    );

    always_comb
    begin
        mem_we      = 1'b0;
        mem_wr_addr = row_reg[ROW_AW-1:0];
        mem_wr_data = '0;
        mem_rd_addr = row_reg[ROW_AW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_ACK_RD:
            begin
                mem_rd_addr = idx_reg[9:BIT_AW];
            end
            ST_ACK_WR:
            begin
                mem_we      = ack_hit;
                mem_wr_addr = idx_reg[9:BIT_AW];
                mem_wr_data = mark_rd_reg | (ROW_W'(1) << idx_reg[BIT_AW-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mark_mem[mem_wr_addr] <= mem_wr_data;
        end
        mark_rd_reg <= mark_mem[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= TOTAL_RESET;
            burst_reg  <= BURST_RESET;
            target_reg <= TARGET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL:  total_reg  <= cfg_data;
                CFG_BURST:  burst_reg  <= cfg_data[4:0];
                CFG_TARGET: target_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= OP_ACK;
            idx_reg       <= '0;
            ack_ok_reg    <= 1'b0;
            row_reg       <= '0;
            acc_reg       <= '0;
            set_below_reg <= '0;
            stale_reg     <= 1'b0;
            confirmed_reg <= '0;
            work_reg      <= '0;
            send_goal_reg <= '0;
            send_cnt_reg  <= '0;
            strobe_reg    <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_we && (cfg_index == CFG_TOTAL))
            begin
                stale_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    row_reg <= row_reg + 1'b1;
                    if (row_reg == (ROW_AW+1)'(ROW_CNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= cmd.opcode;
                        idx_reg    <= cmd.ack_index[9:0];
                        ack_ok_reg <= (cmd.datagram_length != 16'd0)
                                      && (cmd.datagram_length[1:0] == 2'd0)
                                      && (cmd.ack_index < {21'd0, n_eff});
                        row_reg    <= '0;
                        acc_reg    <= '0;
                        if (stale_reg && (n_rows != '0))
                        begin
                            state_reg <= ST_RC_RD;
                        end
                        else
                        begin
                            if (stale_reg)
                            begin
                                set_below_reg <= '0;
                                stale_reg     <= 1'b0;
                            end
                            state_reg <= ST_DISPATCH;
                        end
                    end
                end
                ST_RC_RD:
                begin
                    state_reg <= ST_RC_ACC;
                end
                ST_RC_ACC:
                begin
                    acc_reg <= acc_reg + 11'(unit_ones);
                    row_reg <= row_reg + 1'b1;
                    if (row_reg + 1'b1 == n_rows)
                    begin
                        set_below_reg <= acc_reg + 11'(unit_ones);
                        stale_reg     <= 1'b0;
                        state_reg     <= ST_DISPATCH;
                    end
                    else
                    begin
                        state_reg <= ST_RC_RD;
                    end
                end
                ST_DISPATCH:
                begin
                    state_reg <= (op_reg == OP_ACK) ? ST_ACK_RD : ST_SEND_SETUP;
                end
                ST_ACK_RD:
                begin
                    state_reg <= ST_ACK_WR;
                end
                ST_ACK_WR:
                begin
                    if (ack_hit)
                    begin
                        set_below_reg <= set_below_reg + 1'b1;
                        if (confirmed_reg < FIELD_MAX11)
                        begin
                            confirmed_reg <= confirmed_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_ACK_OUT;
                end
                ST_ACK_OUT:
                begin
                    strobe_reg                 <= 1'b1;
                    result_reg.result_kind     <= KIND_ACK;
                    result_reg.message_index   <= '0;
                    result_reg.acked_count     <= confirmed_reg;
                    result_reg.remaining       <= open_cnt;
                    result_reg.done_res        <= done_now;
                    result_reg.last            <= 1'b1;
                    state_reg                  <= ST_IDLE;
                end
                ST_SEND_SETUP:
                begin
                    row_reg      <= '0;
                    send_cnt_reg <= '0;
                    send_goal_reg <= (open_cnt < 11'(limit)) ? open_cnt[4:0] : limit;
                    if (open_cnt == 11'd0)
                    begin
                        strobe_reg                 <= 1'b1;
                        result_reg.result_kind     <= KIND_NONE;
                        result_reg.message_index   <= '0;
                        result_reg.acked_count     <= confirmed_reg;
                        result_reg.remaining       <= open_cnt;
                        result_reg.done_res        <= done_now;
                        result_reg.last            <= 1'b1;
                        state_reg                  <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_SEND_RD;
                    end
                end
                ST_SEND_RD:
                begin
                    state_reg <= ST_SEND_LOAD;
                end
                ST_SEND_LOAD:
                begin
                    work_reg  <= ~mark_rd_reg & cur_mask;
                    state_reg <= ST_SEND_PICK;
                end
                ST_SEND_PICK:
                begin
                    if (work_reg == '0)
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_SEND_RD;
                    end
                    else
                    begin
                        work_reg     <= work_reg & ~(ROW_W'(1) << unit_first);
                        send_cnt_reg <= send_cnt_reg + 1'b1;
                        strobe_reg                 <= 1'b1;
                        result_reg.result_kind     <= KIND_SEND;
                        result_reg.message_index   <= {row_reg[ROW_AW-1:0], unit_first};
                        result_reg.acked_count     <= confirmed_reg;
                        result_reg.remaining       <= open_cnt;
                        result_reg.done_res        <= done_now;
                        result_reg.last            <= (send_cnt_reg + 1'b1 == send_goal_reg);
                        if (send_cnt_reg + 1'b1 == send_goal_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ($past(state_reg) == ST_ACK_OUT || $past(state_reg) == ST_SEND_SETUP
                           || $past(state_reg) == ST_SEND_PICK))
        else $error("result strobe without an emitting state");

    a_count_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        !stale_reg |-> (set_below_reg <= n_eff))
        else $error("confirmed count below total exceeds total");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND_PICK) |-> (send_cnt_reg < send_goal_reg))
        else $error("send burst overran its goal");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

endmodule
